// ----- src/srq_pkg.sv -----
// Shared constants, types and helpers of the stereo requantizer.
package srq_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DROP_W      = 4;
    localparam int ERR_W       = SAMPLE_BITS - 1;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 63;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_DROP_BITS = 2'd0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] reduced;
        logic [ERR_W-1:0]       err;
        logic [MAG_W-1:0]       mag;
    } t_chan;

    typedef struct packed {
        t_chan left;
        t_chan right;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Mask of the sample bits cleared for a given drop count.
    function automatic logic [SAMPLE_BITS-1:0] srq_mask(input logic [DROP_W-1:0] drop);
        logic [DROP_W-1:0] n;
        n = drop;
        if (32'(drop) > SAMPLE_BITS - 1) begin
            n = DROP_W'(SAMPLE_BITS - 1);
        end
        return ~({SAMPLE_BITS{1'b1}} << n);
    endfunction

endpackage

// ----- src/stereo_requantizer_noise_stats_core.sv -----
// Top level of the stereo requantizer with quantization noise statistics.
// The block takes one stereo frame per cycle and returns one result per frame,
// carrying both truncated samples and the running peak error and saturating
// signal and noise energy sums of each channel. An accepted frame goes into the
// four-entry frame queue between the front and the back part, then the square
// stage and the result register; the queue keeps input accepted while a result
// waits, and input stalls only when it is full. The drop_bits register sits at
// byte address 0. Write it only while no frame is in flight; not enforced here.
module stereo_requantizer_noise_stats_core import srq_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_reduced,
    output logic signed [SAMPLE_BITS-1:0] o_right_reduced,
    output logic [ERR_W-1:0]              o_left_peak_error,
    output logic [ERR_W-1:0]              o_right_peak_error,
    output logic [SUM_W-1:0]              o_left_signal_energy,
    output logic [SUM_W-1:0]              o_left_noise_energy,
    output logic [SUM_W-1:0]              o_right_signal_energy,
    output logic [SUM_W-1:0]              o_right_noise_energy
);

    logic [DROP_W-1:0] r_drop_bits;
    logic              push;
    logic              pop;
    t_item             front_item;
    t_item             queue_item;
    t_queue_status     q_status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DROP_BITS) ? APB_DATA_W'(r_drop_bits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_bits <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_drop_bits <= pwdata[DROP_W-1:0];
        end
    end

    srq_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_left_sample (i_left_sample),
        .i_right_sample(i_right_sample),
        .i_drop_bits   (r_drop_bits),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_item        (front_item)
    );

    srq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (queue_item),
        .o_status(q_status)
    );

    srq_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_item               (queue_item),
        .i_q_status           (q_status),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_left_reduced       (o_left_reduced),
        .o_right_reduced      (o_right_reduced),
        .o_left_peak_error    (o_left_peak_error),
        .o_right_peak_error   (o_right_peak_error),
        .o_left_signal_energy (o_left_signal_energy),
        .o_left_noise_energy  (o_left_noise_energy),
        .o_right_signal_energy(o_right_signal_energy),
        .o_right_noise_energy (o_right_noise_energy)
    );

    a_reduced_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((($unsigned(o_left_reduced) | $unsigned(o_right_reduced))
                          & srq_mask(r_drop_bits)) == '0))
        else $error("reduced sample has cleared bits set");

    a_stats_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_left_signal_energy)
            && $stable(o_right_noise_energy) && $stable(o_left_peak_error))
        else $error("statistics changed while item was held");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_left_peak_error >= $past(o_left_peak_error))
            && (o_right_peak_error >= $past(o_right_peak_error)))
        else $error("peak error decreased");

endmodule

// ----- src/srq_queue.sv -----
// Small FIFO of classified frames between the front and the back part.
module srq_queue import srq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_data,
    input  logic          i_pop,
    output t_item         o_data,
    output t_queue_status o_status
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/srq_front.sv -----
// Front part: accepts frames, truncates samples and splits off error and magnitude.
module srq_front import srq_pkg::*; (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    input  logic [DROP_W-1:0]             i_drop_bits,
    input  t_queue_status                 i_q_status,
    output logic                          o_push,
    output t_item                         o_item
);

    logic [SAMPLE_BITS-1:0] mask;

    function automatic t_chan classify(input logic [SAMPLE_BITS-1:0] u,
                                       input logic [SAMPLE_BITS-1:0] m);
        t_chan c;
        logic [SAMPLE_BITS-1:0] e;
        e         = u & m;
        c.reduced = u & ~m;
        c.err     = e[ERR_W-1:0];
        c.mag     = u[SAMPLE_BITS-1] ? MAG_W'(~u + 1'b1) : MAG_W'(u);
        return c;
    endfunction

    assign mask         = srq_mask(i_drop_bits);
    assign o_in_stall   = i_q_status.full;
    assign o_push       = i_in_valid && !i_q_status.full;
    assign o_item.left  = classify($unsigned(i_left_sample), mask);
    assign o_item.right = classify($unsigned(i_right_sample), mask);

endmodule

// ----- src/srq_back.sv -----
// Back part: squares, saturating energy sums, peak tracking and the result register.
module srq_back import srq_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_item                         i_item,
    input  t_queue_status                 i_q_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_reduced,
    output logic signed [SAMPLE_BITS-1:0] o_right_reduced,
    output logic [ERR_W-1:0]              o_left_peak_error,
    output logic [ERR_W-1:0]              o_right_peak_error,
    output logic [SUM_W-1:0]              o_left_signal_energy,
    output logic [SUM_W-1:0]              o_left_noise_energy,
    output logic [SUM_W-1:0]              o_right_signal_energy,
    output logic [SUM_W-1:0]              o_right_noise_energy
);

    logic                   advance;
    logic                   r_s1_valid;
    t_item                  r_s1_item;
    logic [SQ_W-1:0]        r_sq_sig_l;
    logic [SQ_W-1:0]        r_sq_sig_r;
    logic [SQ_W-1:0]        r_sq_err_l;
    logic [SQ_W-1:0]        r_sq_err_r;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_red_l;
    logic [SAMPLE_BITS-1:0] r_red_r;
    logic [ERR_W-1:0]       r_peak_l;
    logic [ERR_W-1:0]       r_peak_r;
    logic [SUM_W-1:0]       r_sig_l;
    logic [SUM_W-1:0]       r_sig_r;
    logic [SUM_W-1:0]       r_noise_l;
    logic [SUM_W-1:0]       r_noise_r;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [SQ_W-1:0]  add);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W + 1)'(add);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop   = advance && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_item  <= i_item;
            r_sq_sig_l <= SQ_W'(i_item.left.mag) * SQ_W'(i_item.left.mag);
            r_sq_sig_r <= SQ_W'(i_item.right.mag) * SQ_W'(i_item.right.mag);
            r_sq_err_l <= SQ_W'(i_item.left.err) * SQ_W'(i_item.left.err);
            r_sq_err_r <= SQ_W'(i_item.right.err) * SQ_W'(i_item.right.err);
        end
        if (advance && r_s1_valid) begin
            r_red_l <= r_s1_item.left.reduced;
            r_red_r <= r_s1_item.right.reduced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak_l    <= '0;
            r_peak_r    <= '0;
            r_sig_l     <= '0;
            r_sig_r     <= '0;
            r_noise_l   <= '0;
            r_noise_r   <= '0;
        end else if (advance) begin
            r_s1_valid  <= !i_q_status.empty;
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                if (r_s1_item.left.err > r_peak_l) begin
                    r_peak_l <= r_s1_item.left.err;
                end
                if (r_s1_item.right.err > r_peak_r) begin
                    r_peak_r <= r_s1_item.right.err;
                end
                r_sig_l   <= sat_add(r_sig_l, r_sq_sig_l);
                r_sig_r   <= sat_add(r_sig_r, r_sq_sig_r);
                r_noise_l <= sat_add(r_noise_l, r_sq_err_l);
                r_noise_r <= sat_add(r_noise_r, r_sq_err_r);
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_left_reduced        = $signed(r_red_l);
    assign o_right_reduced       = $signed(r_red_r);
    assign o_left_peak_error     = r_peak_l;
    assign o_right_peak_error    = r_peak_r;
    assign o_left_signal_energy  = r_sig_l;
    assign o_left_noise_energy   = r_noise_l;
    assign o_right_signal_energy = r_sig_r;
    assign o_right_noise_energy  = r_noise_r;

endmodule
